// ===== rtl/core/ocp_pkg.sv =====
// Shared types, constants and the arctangent table of the orientation confidence block.
// Used by the controller, the datapath and the top level; depends on nothing.
package ocp_pkg;

   localparam int ENERGY_BITS_DEF = 16;
   localparam int CONF_BITS = 17;
   localparam int ANGLE_BITS = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int IDX_BITS = 5;
   localparam logic [CONF_BITS-1:0] CONF_ONE = 17'h10000;
   localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
   localparam logic signed [16:0] ANGLE_HALF_PI = 17'sd16384;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;
      logic                load;
      logic                prep;
      logic                norm;
      logic                run;
      logic                finish;
      logic [IDX_BITS-1:0] idx;
   } ocp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic norm_done;
   } ocp_status_type;

   // Arctangent of 2^-i in units of pi/32768.
   function automatic logic signed [16:0] atan_unit(input logic [3:0] i);
      logic signed [16:0] a;
      unique case (i)
         4'd0:  a = 17'sd8192;
         4'd1:  a = 17'sd4836;
         4'd2:  a = 17'sd2555;
         4'd3:  a = 17'sd1297;
         4'd4:  a = 17'sd651;
         4'd5:  a = 17'sd326;
         4'd6:  a = 17'sd163;
         4'd7:  a = 17'sd81;
         4'd8:  a = 17'sd41;
         4'd9:  a = 17'sd20;
         4'd10: a = 17'sd10;
         4'd11: a = 17'sd5;
         4'd12: a = 17'sd3;
         4'd13: a = 17'sd1;
         4'd14: a = 17'sd1;
         default: a = 17'sd0;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/core/ocp_ctrl.sv =====
// Sequencer of the orientation confidence block: handshakes and step commands.
// Depends on ocp_pkg.
module ocp_ctrl import ocp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  ocp_status_type status,
   output ocp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_PREP, S_NORM, S_RUN, S_FIN
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands follow the state directly.
   always_comb begin
      cmd         = '0;
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.load    = (state_ff == S_LOAD);
      cmd.prep    = (state_ff == S_PREP);
      cmd.norm    = (state_ff == S_NORM);
      cmd.run     = (state_ff == S_RUN);
      cmd.finish  = (state_ff == S_FIN) && out_free;
      cmd.idx     = cnt_ff;
   end

   // Next state, iteration count and result valid.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_LOAD;
         S_LOAD: state_in = S_PREP;
         S_PREP: state_in = S_NORM;
         S_NORM: begin
            cnt_in = '0;
            if (status.norm_done) state_in = S_RUN;
         end
         S_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_BITS'(CORDIC_STEPS)) state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/ocp_datapath.sv =====
// Datapath: energy sort, confidence divider, CORDIC arctangent, frame range, result word.
// Depends on ocp_pkg; driven by ocp_ctrl commands.
module ocp_datapath import ocp_pkg::*; #(
   parameter int EnergyBits = ENERGY_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [EnergyBits-1:0]        req_energy_deg0,
   input  logic [EnergyBits-1:0]        req_energy_deg45,
   input  logic [EnergyBits-1:0]        req_energy_deg90,
   input  logic [EnergyBits-1:0]        req_energy_deg135,
   input  logic                         req_frame_last,
   input  ocp_cmd_type                  cmd,
   output ocp_status_type               status,
   output logic [CONF_BITS-1:0]         rsp_confidence,
   output logic signed [ANGLE_BITS-1:0] rsp_dominant_angle,
   output logic                         rsp_ratio_undefined,
   output logic                         rsp_frame_done,
   output logic [CONF_BITS-1:0]         rsp_frame_conf_min,
   output logic [CONF_BITS-1:0]         rsp_frame_conf_max
);

   localparam int MagBits = (EnergyBits + 17 > 47) ? EnergyBits + 17 : 47;
   localparam int WBits   = MagBits + 3;

   logic [EnergyBits-1:0]        e_ff [4];
   logic                         last_ff;
   logic [EnergyBits-1:0]        l_ff;
   logic [EnergyBits:0]          r_ff, r_in;
   logic [CONF_BITS-1:0]         q_ff, q_in;
   logic signed [EnergyBits:0]   d1_ff;
   logic                         d2neg_ff;
   logic [EnergyBits+15:0]       p_ff;
   logic signed [WBits-1:0]      x_ff, y_ff, x_in, y_in;
   logic signed [16:0]           z_ff, z_in;
   logic                         xneg_ff, xzero_ff, yzero_ff;
   logic [CONF_BITS-1:0]         rmin_ff, rmax_ff;
   logic [CONF_BITS-1:0]         conf_ff;
   logic signed [ANGLE_BITS-1:0] ang_ff;
   logic                         undef_ff, done_ff;
   logic [CONF_BITS-1:0]         fmin_ff, fmax_ff;

   logic [EnergyBits-1:0]      largest, second;
   logic signed [EnergyBits:0] d1, d2;
   logic [EnergyBits-1:0]      d2abs;
   logic signed [WBits-1:0]    d1w, pw, xs, ys;
   logic [EnergyBits:0]        rs;
   logic signed [WBits-1:0]    dx, dy;
   logic [3:0]                 step;
   logic                       undef;
   logic [CONF_BITS-1:0]       conf, nmin, nmax;
   logic signed [16:0]         zc, ang;

   // Largest and second largest energy, in descending sort order.
   always_comb begin
      largest = '0;
      second  = '0;
      for (int k = 0; k < 4; k++) begin
         if (e_ff[k] > largest) begin
            second  = largest;
            largest = e_ff[k];
         end else if (e_ff[k] > second) begin
            second = e_ff[k];
         end
      end
   end

   // Orientation differences.
   assign d1    = $signed({1'b0, e_ff[0]}) - $signed({1'b0, e_ff[2]});
   assign d2    = $signed({1'b0, e_ff[1]}) - $signed({1'b0, e_ff[3]});
   assign d2abs = d2[EnergyBits] ? EnergyBits'(-d2) : EnergyBits'(d2);

   // Projection sums from the registered product.
   assign d1w = WBits'(d1_ff);
   assign pw  = WBits'($signed({1'b0, p_ff}));
   assign xs  = ((d1_ff > 0) ? (d1w <<< 16) : '0) + (d2neg_ff ? -pw : pw);
   assign ys  = ((d1_ff > 0) ? '0 : ((-d1w) <<< 16)) + pw;

   // Normalization ends at the 2^46 limit or when a special case decides the angle.
   assign status.norm_done = yzero_ff || xzero_ff || (|x_ff[WBits-1:46]) ||
                             (|y_ff[WBits-1:46]);

   // One restoring division step per run cycle; the first has no shift.
   assign rs = (cmd.idx == '0) ? r_ff : {r_ff[EnergyBits-1:0], 1'b0};

   // One CORDIC vectoring step.
   assign step = cmd.idx[3:0];
   assign dx   = y_ff >>> step;
   assign dy   = x_ff >>> step;

   always_comb begin
      r_in = r_ff;
      q_in = q_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      priority if (cmd.prep) begin
         x_in = xs[WBits-1] ? -xs : xs;
         y_in = ys;
         z_in = '0;
      end else if (cmd.norm) begin
         if (!status.norm_done) begin
            if (!(|x_ff[WBits-1:38]) && !(|y_ff[WBits-1:38])) begin
               x_in = x_ff <<< 8;
               y_in = y_ff <<< 8;
            end else begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end
         end
      end else if (cmd.run) begin
         if (rs >= {1'b0, l_ff}) begin
            r_in = rs - {1'b0, l_ff};
            q_in = {q_ff[CONF_BITS-2:0], 1'b1};
         end else begin
            r_in = rs;
            q_in = {q_ff[CONF_BITS-2:0], 1'b0};
         end
         if (!cmd.idx[IDX_BITS-1]) begin
            if (!y_ff[WBits-1]) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_unit(step);
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_unit(step);
            end
         end
      end else begin
         r_in = r_ff;
      end
   end

   // Final angle, confidence and frame range.
   always_comb begin
      undef = (l_ff == '0);
      conf  = undef ? '0 : q_ff;
      zc    = (z_ff < 0) ? 17'sd0 : ((z_ff > ANGLE_HALF_PI) ? ANGLE_HALF_PI : z_ff);
      if (yzero_ff) begin
         ang = '0;
      end else if (xzero_ff) begin
         ang = ANGLE_HALF_PI;
      end else begin
         ang = xneg_ff ? -zc : zc;
      end
      nmin = (!undef && conf < rmin_ff) ? conf : rmin_ff;
      nmax = (!undef && conf > rmax_ff) ? conf : rmax_ff;
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         e_ff[0] <= req_energy_deg0;
         e_ff[1] <= req_energy_deg45;
         e_ff[2] <= req_energy_deg90;
         e_ff[3] <= req_energy_deg135;
         last_ff <= req_frame_last;
      end
      if (cmd.load) begin
         l_ff     <= largest;
         r_ff     <= {1'b0, largest - second};
         q_ff     <= '0;
         d1_ff    <= d1;
         d2neg_ff <= d2[EnergyBits];
         p_ff     <= d2abs * INV_SQRT2_Q16;
      end else begin
         r_ff <= r_in;
         q_ff <= q_in;
      end
      if (cmd.prep) begin
         xneg_ff  <= xs[WBits-1];
         xzero_ff <= (xs == '0);
         yzero_ff <= (ys == '0);
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   // Result word.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         conf_ff  <= conf;
         ang_ff   <= ANGLE_BITS'(ang);
         undef_ff <= undef;
         done_ff  <= last_ff;
         fmin_ff  <= last_ff ? nmin : '0;
         fmax_ff  <= last_ff ? nmax : '0;
      end
   end

   // Running confidence range; cleared after each frame end.
   always_ff @(posedge clock) begin
      if (reset) begin
         rmin_ff <= CONF_ONE;
         rmax_ff <= '0;
      end else if (cmd.finish) begin
         rmin_ff <= last_ff ? CONF_ONE : nmin;
         rmax_ff <= last_ff ? '0 : nmax;
      end
   end

   assign rsp_confidence      = conf_ff;
   assign rsp_dominant_angle  = ang_ff;
   assign rsp_ratio_undefined = undef_ff;
   assign rsp_frame_done      = done_ff;
   assign rsp_frame_conf_min  = fmin_ff;
   assign rsp_frame_conf_max  = fmax_ff;

endmodule

// ===== rtl/core/orientation_confidence_pixel.sv =====
// Orientation confidence of one pixel: takes four filter energies (0, 45, 90, 135 degrees)
// per word and returns the confidence 1 - second/largest in Q1.16, the dominant angle in
// units of pi/32768 and, on the frame's last pixel, the frame's confidence range. A pixel
// goes from acceptance to result through the setup states load and prep, the normalizing
// shift loop before the arctangent, the shared iteration counter that drives the divider
// and the CORDIC, and a final state that writes the result register. A previous result
// that still waits in the result register holds off that last write. The next word is
// accepted once the result is written, even if it waits.
module orientation_confidence_pixel import ocp_pkg::*; #(
   parameter int EnergyBits = ENERGY_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [EnergyBits-1:0]        req_energy_deg0,
   input  logic [EnergyBits-1:0]        req_energy_deg45,
   input  logic [EnergyBits-1:0]        req_energy_deg90,
   input  logic [EnergyBits-1:0]        req_energy_deg135,
   input  logic                         req_frame_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CONF_BITS-1:0]         rsp_confidence,
   output logic signed [ANGLE_BITS-1:0] rsp_dominant_angle,
   output logic                         rsp_ratio_undefined,
   output logic                         rsp_frame_done,
   output logic [CONF_BITS-1:0]         rsp_frame_conf_min,
   output logic [CONF_BITS-1:0]         rsp_frame_conf_max
);

   ocp_cmd_type    cmd;
   ocp_status_type status;

   ocp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ocp_datapath #(.EnergyBits(EnergyBits)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_energy_deg0     (req_energy_deg0),
      .req_energy_deg45    (req_energy_deg45),
      .req_energy_deg90    (req_energy_deg90),
      .req_energy_deg135   (req_energy_deg135),
      .req_frame_last      (req_frame_last),
      .cmd                 (cmd),
      .status              (status),
      .rsp_confidence      (rsp_confidence),
      .rsp_dominant_angle  (rsp_dominant_angle),
      .rsp_ratio_undefined (rsp_ratio_undefined),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_frame_conf_min  (rsp_frame_conf_min),
      .rsp_frame_conf_max  (rsp_frame_conf_max)
   );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for orientation_confidence_pixel: random and directed pixel words,
// a scoreboard class that predicts confidence, angle and frame range, random stalls.
// Depends on ocp_pkg and the orientation_confidence_pixel RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ocp_pkg::*;

   localparam int EB = ENERGY_BITS_DEF;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [CONF_BITS-1:0]         conf;
      logic signed [ANGLE_BITS-1:0] angle;
      logic                         undef_flag;
      logic                         done;
      logic [CONF_BITS-1:0]         fmin;
      logic [CONF_BITS-1:0]         fmax;
   } pixel_result_type;

   int error_count = 0;

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   class orientation_scoreboard;
      pixel_result_type pending[$];
      logic [CONF_BITS-1:0] run_min = CONF_ONE;
      logic [CONF_BITS-1:0] run_max = '0;

      // Arithmetic floor shift for signed values.
      static function longint floor_shift(longint v, int k);
         return v >>> k;
      endfunction

      // First-quadrant arctangent by 16 CORDIC vectoring steps.
      static function longint quadrant_atan(longint x, longint y);
         longint z, dx, dy;
         z = 0;
         if (y == 0) return 0;
         if (x == 0) return 16384;
         while (x < (64'sd1 <<< 46) && y < (64'sd1 <<< 46)) begin
            x = x <<< 1;
            y = y <<< 1;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
               x += dx; y -= dy; z += atan_unit(i[3:0]);
            end else begin
               x -= dx; y += dy; z -= atan_unit(i[3:0]);
            end
         end
         if (z < 0) z = 0;
         if (z > 16384) z = 16384;
         return z;
      endfunction

      // Predict the result word of one accepted pixel.
      function void note_pixel(logic [EB-1:0] e0, e45, e90, e135, logic last);
         longint e[4], big, sec, d1, d2, x, y, ang;
         pixel_result_type r;
         e[0] = longint'(e0); e[1] = longint'(e45);
         e[2] = longint'(e90); e[3] = longint'(e135);
         big = 0; sec = 0;
         foreach (e[k]) begin
            if (e[k] > big) begin
               sec = big; big = e[k];
            end else if (e[k] > sec) begin
               sec = e[k];
            end
         end
         r = '0;
         r.undef_flag = (big == 0);
         if (big != 0) begin
            r.conf = CONF_BITS'(((big - sec) <<< 16) / big);
            if (r.conf < run_min) run_min = r.conf;
            if (r.conf > run_max) run_max = r.conf;
         end
         d1 = e[0] - e[2];
         d2 = e[1] - e[3];
         if (d1 > 0) begin
            x = d1 * 65536; y = 0;
         end else begin
            x = 0; y = -d1 * 65536;
         end
         if (d2 > 0) begin
            x += d2 * 46341; y += d2 * 46341;
         end else begin
            x -= -d2 * 46341; y += -d2 * 46341;
         end
         if (x == 0 && y == 0) ang = 0;
         else if (x >= 0) ang = quadrant_atan(x, y);
         else ang = -quadrant_atan(-x, y);
         r.angle = ang[15:0];
         r.done = last;
         if (last) begin
            r.fmin = run_min; r.fmax = run_max;
            run_min = CONF_ONE; run_max = '0;
         end
         pending = {pending, r};
      endfunction

      // Compare one accepted result word with the oldest prediction.
      task check_result(pixel_result_type got);
         pixel_result_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
            return;
         end
         w = pending.pop_front();
         if (got.conf !== w.conf) report_mismatch("confidence", got.conf, w.conf);
         if (got.angle !== w.angle) report_mismatch("angle", got.angle, w.angle);
         if (got.undef_flag !== w.undef_flag)
            report_mismatch("ratio_undefined", got.undef_flag, w.undef_flag);
         if (got.done !== w.done) report_mismatch("frame_done", got.done, w.done);
         if (got.fmin !== w.fmin) report_mismatch("frame_conf_min", got.fmin, w.fmin);
         if (got.fmax !== w.fmax) report_mismatch("frame_conf_max", got.fmax, w.fmax);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, req_stall, rsp_valid;
   logic [EB-1:0] req_energy_deg0 = '0, req_energy_deg45 = '0;
   logic [EB-1:0] req_energy_deg90 = '0, req_energy_deg135 = '0;
   logic req_frame_last = 0;
   logic [CONF_BITS-1:0] rsp_confidence, rsp_frame_conf_min, rsp_frame_conf_max;
   logic signed [ANGLE_BITS-1:0] rsp_dominant_angle;
   logic rsp_ratio_undefined, rsp_frame_done;
   bit stimulus_done = 0, long_hold = 0;
   int idle_cycles = 0;

   orientation_scoreboard board = new();

   orientation_confidence_pixel dut (.*);

   initial forever #5 clock = ~clock;

   // Random gap length: mostly short, sometimes long.
   function automatic int gap_length();
      int p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one pixel word and wait until it is accepted.
   task automatic send_pixel(logic [EB-1:0] a, b, c, d, logic last);
      req_valid <= 1;
      req_energy_deg0 <= a; req_energy_deg45 <= b;
      req_energy_deg90 <= c; req_energy_deg135 <= d;
      req_frame_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pixel(a, b, c, d, last);
   endtask

   // Energy with a bias toward edge values and near-ties.
   function automatic logic [EB-1:0] pick_energy(logic [EB-1:0] ref_val);
      int p = $urandom_range(0, 99);
      if (p < 10) return '0;
      if (p < 15) return '1;
      if (p < 30) return EB'(ref_val + $urandom_range(0, 3) - 1);
      if (p < 45) return EB'($urandom_range(0, 255));
      return EB'($urandom);
   endfunction

   // Sender: directed pixels, then random frames with gaps.
   initial begin
      logic [EB-1:0] a, b, c, d;
      int gap;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_pixel(0, 0, 0, 0, 0);
      send_pixel('1, '1, '1, '1, 0);
      send_pixel('1, 0, 0, 0, 0);
      send_pixel(0, '1, 0, 0, 0);
      send_pixel(0, 0, '1, 0, 0);
      send_pixel(0, 0, 0, '1, 1);
      send_pixel(0, 0, 0, 0, 1);
      send_pixel(100, 7, 100, 7, 0);
      send_pixel(5, 9, 5, 3, 0);
      send_pixel(5, 3, 5, 9, 0);
      send_pixel(1, 0, 0, 0, 0);
      send_pixel(0, 1, 0, 0, 0);
      send_pixel(0, 0, 1, 0, 0);
      send_pixel(0, 0, 0, 1, 0);
      send_pixel(16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, 1);
      send_pixel(1, 1, 2, 0, 0);
      send_pixel(16'h8000, 16'h7FFF, 0, 16'h8000, 1);
      for (int n = 0; n < 1900; n++) begin
         a = pick_energy(EB'($urandom));
         b = pick_energy(a);
         c = pick_energy(b);
         d = pick_energy(c);
         if (n == 400) long_hold = 1;
         gap = gap_length();
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         send_pixel(a, b, c, d, $urandom_range(0, 15) == 0);
      end
      req_valid <= 0;
      stimulus_done = 1;
   end

   // Receiver stall pattern, with one long hold-off while words keep coming.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            long_hold = 0;
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
         rsp_stall <= (gap > 0);
         repeat (gap > 0 ? gap : 1) @(posedge clock);
      end
   end

   // Accepted result words go to the scoreboard; watchdog on idle cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result({rsp_confidence, rsp_dominant_angle, rsp_ratio_undefined,
                                rsp_frame_done, rsp_frame_conf_min, rsp_frame_conf_max});
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // End of run: drain, settle, then verdict; or time out.
   initial begin
      fork
         begin
            wait (stimulus_done && board.pending.size() == 0);
            repeat (60) @(posedge clock);
         end
         begin
            wait (idle_cycles >= IDLE_LIMIT);
            error_count++;
         end
      join_any
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/ocp_pkg.sv
rtl/core/ocp_ctrl.sv
rtl/core/ocp_datapath.sv
rtl/core/orientation_confidence_pixel.sv
bench/tb.sv
